FILE: rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared sizes, action and error codes, and the control and slot types that
// travel between the top level and the storage cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Number of storage cells and the width of one stored value.
    localparam int DEPTH   = 16;
    localparam int VALUE_W = 32;
    // Occupancy counts from zero up to DEPTH inclusive.
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]   t_count;

    // Action codes of a command transfer; codes 6 and 7 change nothing.
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CONTAINS   = 3'd4,
        ACT_REMOVE     = 3'd5
    } t_action;

    // Error codes reported with each result.
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    // Contents of one cell as its neighbors see it.
    typedef struct packed {
        logic   valid;
        t_value value;
    } t_slot;

    // Operation broadcast to every cell for one cycle.
    typedef struct packed {
        logic   shift_right;   // push at the front
        logic   push_back;     // write the first free cell
        logic   shift_left;    // pop at the front
        logic   pop_back;      // drop the last held cell
        logic   remove;        // close up over the first match
        t_value value;         // operand for pushes and searches
    } t_cell_ctrl;

endpackage

FILE: rtl/core/bdq_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one deque action and its operand.
// ----------------------------------------------------------------------------
interface bdq_cmd_if;
    import bdq_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  action;
    t_value      value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

FILE: rtl/core/bdq_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the result of one deque action.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
    import bdq_pkg::*;

    logic        valid;
    logic        ready;
    t_value      front_value;
    t_value      back_value;
    logic        found;
    t_count      occupancy;
    logic [1:0]  error_code;

    modport source (output valid, output front_value, output back_value, output found,
                    output occupancy, output error_code, input ready);
    modport sink   (input valid, input front_value, input back_value, input found,
                    input occupancy, input error_code, output ready);
endinterface

FILE: rtl/core/bdq_cell.sv
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one entry and its valid bit. Takes its next contents from itself, from
// either neighbor or from the operand, and passes a running match flag down the chain.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdq_pkg::t_cell_ctrl i_ctrl,
    input  bdq_pkg::t_slot      i_prev,
    input  bdq_pkg::t_slot      i_next,
    input  logic                i_hit,
    output bdq_pkg::t_slot      o_slot,
    output logic                o_hit
);
    import bdq_pkg::*;

    logic   r_valid;
    t_value r_value;
    logic   n_valid;
    t_value n_value;
    logic   w_match;

    // A held entry equal to the operand; the flag stays high from the first
    // match toward the back, which marks the cells that close up on remove.
    assign w_match = r_valid && (r_value == i_ctrl.value);
    assign o_hit   = i_hit || w_match;

    // Next contents of the cell.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift_right) begin
            n_valid = i_prev.valid;
            n_value = i_prev.value;
        end else if (i_ctrl.push_back) begin
            if (!r_valid && i_prev.valid) begin
                n_valid = 1'b1;
                n_value = i_ctrl.value;
            end
        end else if (i_ctrl.shift_left || (i_ctrl.remove && o_hit)) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
        end else if (i_ctrl.pop_back) begin
            if (r_valid && !i_next.valid) begin
                n_valid = 1'b0;
            end
        end
    end

    // Valid bit is control state; the entry itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.value = r_value;

endmodule

FILE: rtl/core/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// Bounded deque with search
// Double-ended queue of up to DEPTH values with push and pop at both ends,
// a contains test and removal of the first match from the front.
// ----------------------------------------------------------------------------
// The row of cells updates at the command transfer, and the result register
// then loads from the row once it is free; the next command is taken only
// after that load, so commands are handled one at a time.
// All cells compare and shift in parallel; removal needs a match flag that
// ripples through the chain of cells. A finished result waits in its own
// register, so a new command can be taken while it is not yet collected.
// A push while full or a pop while empty changes nothing and reports an error.
module bounded_deque_with_search (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bdq_cmd_if.sink   i_cmd,
    bdq_rsp_if.source o_rsp
);
    import bdq_pkg::*;

    t_slot      w_slot [0:DEPTH+1];
    logic       w_hit  [0:DEPTH];
    logic [DEPTH-1:0] w_valid;
    t_cell_ctrl w_ctrl;
    t_action    w_act;
    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    logic       w_load;
    t_value     w_back;

    logic       r_busy;
    logic       n_busy;
    t_count     r_count;
    t_count     n_count;
    logic       r_found;
    logic       n_found;
    t_err       r_err;
    t_err       n_err;

    logic       r_out_valid;
    t_value     r_front_value;
    t_value     r_back_value;
    logic       r_out_found;
    t_count     r_occupancy;
    t_err       r_error_code;

    assign w_act    = t_action'(i_cmd.action);
    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_full   = w_valid[DEPTH-1];
    assign w_empty  = !w_valid[0];

    // Chain ends: a pushed value stands before the front, nothing after the back.
    assign w_slot[0].valid       = 1'b1;
    assign w_slot[0].value       = i_cmd.value;
    assign w_slot[DEPTH+1].valid = 1'b0;
    assign w_slot[DEPTH+1].value = '0;
    assign w_hit[0]              = 1'b0;

    // Decode the accepted command into one cell operation.
    always_comb begin
        w_ctrl             = '0;
        w_ctrl.value       = i_cmd.value;
        n_count            = r_count;
        n_found            = 1'b0;
        n_err              = ERR_OK;
        if (w_accept) begin
            unique case (w_act) inside
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    if (w_full) begin
                        n_err = ERR_FULL;
                    end else begin
                        w_ctrl.shift_right = (w_act == ACT_PUSH_FRONT);
                        w_ctrl.push_back   = (w_act == ACT_PUSH_BACK);
                        n_count            = r_count + t_count'(1);
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK: begin
                    if (w_empty) begin
                        n_err = ERR_EMPTY;
                    end else begin
                        w_ctrl.shift_left = (w_act == ACT_POP_FRONT);
                        w_ctrl.pop_back   = (w_act == ACT_POP_BACK);
                        n_count           = r_count - t_count'(1);
                    end
                end
                ACT_CONTAINS: begin
                    n_found = w_hit[DEPTH];
                end
                ACT_REMOVE: begin
                    n_found       = w_hit[DEPTH];
                    w_ctrl.remove = 1'b1;
                    if (w_hit[DEPTH]) begin
                        n_count = r_count - t_count'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Row of storage cells, front at index zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_slot[g]),
            .i_next  (w_slot[g+2]),
            .i_hit   (w_hit[g]),
            .o_slot  (w_slot[g+1]),
            .o_hit   (w_hit[g+1])
        );
        assign w_valid[g] = w_slot[g+1].valid;
    end

    // The back entry is the one held cell whose successor is empty.
    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_slot[i+1].valid && !w_slot[i+2].valid) begin
                w_back = w_back | w_slot[i+1].value;
            end
        end
    end

    // Result loads while a command is in flight, once the result register is free.
    assign w_load      = r_busy && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_busy;

    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_load) begin
            n_busy = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-command status, held until the result register loads.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found <= n_found;
            r_err   <= n_err;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_front_value <= w_slot[1].valid ? w_slot[1].value : '0;
            r_back_value  <= w_back;
            r_out_found   <= r_found;
            r_occupancy   <= r_count;
            r_error_code  <= r_err;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.front_value = r_front_value;
    assign o_rsp.back_value  = r_back_value;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.occupancy   = r_occupancy;
    assign o_rsp.error_code  = r_error_code;

    // The count register always agrees with the number of held cells.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == r_count)
        else $error("occupancy count differs from held cells");

    // Held cells always form an unbroken run from the front.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, w_valid} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("held cells are not contiguous from the front");

    // A full error is reported only with a full queue.
    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.error_code == ERR_FULL) |-> o_rsp.occupancy == t_count'(DEPTH))
        else $error("full error reported below capacity");

    // No command is taken while a result is still being formed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && !i_cmd.ready)
        else $error("command taken while busy");

endmodule
